// File: hdl/udsd_pkg.sv
// Shared types and codes for the diagnostic download server.
package udsd_pkg;

	localparam int IMAGE_BYTES_DEF = 131072;

	// service identifiers
	localparam logic [7:0] SID_SESSION  = 8'h10;
	localparam logic [7:0] SID_DOWNLOAD = 8'h34;
	localparam logic [7:0] SID_TRANSFER = 8'h36;
	localparam logic [7:0] SID_EXIT     = 8'h37;
	localparam logic [7:0] SID_NEGATIVE = 8'h7F;
	localparam logic [7:0] POS_OFFSET   = 8'h40;

	// negative response codes
	localparam logic [7:0] NRC_GENERAL  = 8'h10;
	localparam logic [7:0] NRC_NOT_SUPP = 8'h11;
	localparam logic [7:0] NRC_LENGTH   = 8'h13;
	localparam logic [7:0] NRC_COND     = 8'h22;
	localparam logic [7:0] NRC_RANGE    = 8'h31;
	localparam logic [7:0] NRC_SEQUENCE = 8'h73;

	// download reply fields
	localparam logic [7:0] LEN_FORMAT   = 8'h20;
	localparam logic [7:0] BLOCK_LEN    = 8'h00;

	// phase codes
	localparam logic [1:0] PH_IDLE      = 2'd0;
	localparam logic [1:0] PH_REQUESTED = 2'd1;
	localparam logic [1:0] PH_PROGRESS  = 2'd2;
	localparam logic [1:0] PH_COMPLETE  = 2'd3;

	// one response as handed from the engine to the output stage
	typedef struct packed {
		logic       valid;
		logic [1:0] count;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       active;
		logic       complete;
	} resp_t;

endpackage

// File: hdl/uds_download_server_core.sv
// Top level of the diagnostic download server: engine, image store, response output.
// A final request byte or a read shows its first output word in the cycle after accept.
// Throughput: one request byte per cycle; non-final bytes are taken even while output stalls.
// A final byte or a read waits for the previous response to drain (up to 3 words, one a cycle while rsp_ready is high).
// Reset (arst_n low) clears session, download state and message position at once.
// The image store has no reset; never-written entries read back undefined.
module uds_download_server_core #(
	parameter int IMAGE_BYTES = udsd_pkg::IMAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        opcode,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	input  logic [16:0] read_address,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        kind,
	output logic [7:0]  out_byte,
	output logic        last_of_response,
	output logic        dl_open,
	output logic        download_complete
);

	localparam int AW = $clog2(IMAGE_BYTES);
	localparam int XW = ((AW > 17) ? AW : 17) + 1;

	udsd_pkg::resp_t resp;
	logic            accept, msg_accept, rd_accept, out_free, last_word;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [7:0]      wr_data;
	logic [XW-1:0]   ra_w;
	logic            ra_ok;

	logic [7:0]      mem [IMAGE_BYTES];
	logic [7:0]      rd_q;
	logic            rd_ok_q;

	logic            vld_q, kind_q, act_q, cmp_q;
	logic [1:0]      cnt_q, idx_q;
	logic [7:0]      b0_q, b1_q, b2_q;

	// handshake: bytes that raise no result never wait for the output
	assign last_word  = kind_q || (idx_q == cnt_q - 2'd1);
	assign out_free   = !vld_q || (rsp_ready && last_word);
	assign req_ready  = out_free || (!opcode && !end_of_message);
	assign accept     = req_valid && req_ready;
	assign msg_accept = accept && !opcode;
	assign rd_accept  = accept && opcode;

	udsd_engine #(.IMAGE_BYTES(IMAGE_BYTES), .AW(AW)) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (msg_accept),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.resp           (resp),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.wr_data        (wr_data)
	);

	// image store
	assign ra_w  = XW'(read_address);
	assign ra_ok = ra_w < XW'(IMAGE_BYTES);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_accept) begin
			rd_q    <= mem[ra_w[AW-1:0]];
			rd_ok_q <= ra_ok;
		end
	end

	// output stage, one word per cycle while rsp_ready is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (rd_accept || (msg_accept && end_of_message)) begin
			vld_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (vld_q && rsp_ready) begin
			if (last_word) vld_q <= 1'b0;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_accept) begin
			kind_q <= 1'b1;
			cnt_q  <= 2'd1;
			act_q  <= resp.active;
			cmp_q  <= resp.complete;
		end else if (msg_accept && end_of_message) begin
			kind_q <= 1'b0;
			cnt_q  <= resp.count;
			b0_q   <= resp.b0;
			b1_q   <= resp.b1;
			b2_q   <= resp.b2;
			act_q  <= resp.active;
			cmp_q  <= resp.complete;
		end
	end

	assign rsp_valid         = vld_q;
	assign kind              = kind_q;
	assign last_of_response  = last_word;
	assign dl_open           = act_q;
	assign download_complete = cmp_q;

	always_comb begin
		if (kind_q) out_byte = rd_ok_q ? rd_q : 8'h00;
		else begin
			unique case (idx_q)
				2'd0:    out_byte = b0_q;
				2'd1:    out_byte = b1_q;
				default: out_byte = b2_q;
			endcase
		end
	end

	// checks
	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind |-> last_of_response)
		else $error("read word without last mark");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (opcode || end_of_message) |=> rsp_valid)
		else $error("no output after result-raising word");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(dl_open && download_complete))
		else $error("download active and complete together");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !kind |-> idx_q < cnt_q)
		else $error("response index past count");

endmodule

// File: hdl/udsd_engine.sv
// Request decoder and download state: judges each message on its final byte.
module udsd_engine #(
	parameter int IMAGE_BYTES = udsd_pkg::IMAGE_BYTES_DEF,
	parameter int AW = $clog2(IMAGE_BYTES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             end_of_message,
	output udsd_pkg::resp_t  resp,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output logic [7:0]       wr_data
);

	localparam int POS_CAP = IMAGE_BYTES * 2 + 16;
	localparam int PW = $clog2(POS_CAP + 1);
	localparam int LW = $clog2(IMAGE_BYTES + 1);
	localparam int SW = PW + 1;

	logic [PW-1:0] pos_q;
	logic [LW-1:0] br_q, il_q;
	logic [7:0]    svc_q, sec_q, fmt_q, exp_q;
	logic [63:0]   size_q;
	logic          prog_q, act_q, rr_q;
	logic [1:0]    phase_q;

	logic [PW-1:0] pos_d;
	logic [LW-1:0] br_d, il_d;
	logic [7:0]    svc_d, sec_d, fmt_d, exp_d;
	logic [63:0]   size_d;
	logic          prog_d, act_d, rr_d;
	logic [1:0]    phase_d;
	logic [3:0]    al, sl;
	logic [SW-1:0] p_w, len_w, q_w, a_w, sum_w;
	logic [1:0]    n_d;
	logic [7:0]    r0, r1, r2;

	always_comb begin
		p_w    = SW'(pos_q);
		len_w  = p_w + SW'(1);
		svc_d  = svc_q;
		sec_d  = sec_q;
		fmt_d  = fmt_q;
		size_d = size_q;
		br_d   = br_q;
		il_d   = il_q;
		exp_d  = exp_q;
		prog_d = prog_q;
		act_d  = act_q;
		rr_d   = rr_q;
		phase_d = phase_q;
		n_d    = 2'd0;
		r0     = 8'h00;
		r1     = 8'h00;
		r2     = 8'h00;
		wr_en  = 1'b0;

		// capture header bytes
		if (pos_q == '0) begin
			svc_d  = data_byte;
			sec_d  = 8'h00;
			fmt_d  = 8'h00;
			size_d = 64'd0;
		end else if (p_w == SW'(1)) begin
			sec_d = data_byte;
		end else if (p_w == SW'(2)) begin
			fmt_d = data_byte;
		end
		al = fmt_d[7:4];
		sl = fmt_d[3:0];

		// size field of request download; address bytes are skipped
		q_w = p_w - SW'(3);
		if (svc_d == udsd_pkg::SID_DOWNLOAD && p_w >= SW'(3)) begin
			if (q_w >= SW'(al) && (q_w - SW'(al)) < SW'(sl) && sl <= 4'd8)
				size_d = {size_q[55:0], data_byte};
		end

		// transfer data goes straight to the store
		a_w = SW'(br_q) + (p_w - SW'(2));
		wr_addr = a_w[AW-1:0];
		wr_data = data_byte;
		if (svc_d == udsd_pkg::SID_TRANSFER && p_w >= SW'(2) && act_q && rr_q &&
		    sec_d == exp_q && a_w < SW'(il_q) && a_w < SW'(IMAGE_BYTES))
			wr_en = accept;

		sum_w = SW'(br_q) + len_w - SW'(2);

		// message position and final judgment
		if (!end_of_message) begin
			pos_d = (len_w < SW'(POS_CAP)) ? len_w[PW-1:0] : PW'(POS_CAP);
		end else begin
			pos_d = '0;
			n_d = 2'd3;
			r0  = udsd_pkg::SID_NEGATIVE;
			r1  = svc_d;
			unique case (svc_d)
				udsd_pkg::SID_SESSION: begin
					if (len_w != SW'(2)) r2 = udsd_pkg::NRC_LENGTH;
					else if (sec_d != 8'd1 && sec_d != 8'd2) r2 = udsd_pkg::NRC_NOT_SUPP;
					else begin
						prog_d = (sec_d == 8'd2);
						n_d = 2'd2;
						r0  = svc_d + udsd_pkg::POS_OFFSET;
						r1  = sec_d;
					end
				end
				udsd_pkg::SID_DOWNLOAD: begin
					if (len_w < SW'(3)) r2 = udsd_pkg::NRC_LENGTH;
					else if (!prog_q) r2 = udsd_pkg::NRC_COND;
					else if (al == 4'd0 || sl == 4'd0) r2 = udsd_pkg::NRC_RANGE;
					else if (al > 4'd4 || sl > 4'd8) r2 = udsd_pkg::NRC_RANGE;
					else if (len_w != SW'(3) + SW'(al) + SW'(sl)) r2 = udsd_pkg::NRC_LENGTH;
					else if (size_d == 64'd0) r2 = udsd_pkg::NRC_RANGE;
					else if (size_d > 64'(IMAGE_BYTES)) begin
						rr_d = 1'b0;
						r2   = udsd_pkg::NRC_GENERAL;
					end else begin
						il_d    = size_d[LW-1:0];
						br_d    = '0;
						exp_d   = 8'd1;
						phase_d = udsd_pkg::PH_REQUESTED;
						act_d   = 1'b1;
						rr_d    = 1'b1;
						r0 = svc_d + udsd_pkg::POS_OFFSET;
						r1 = udsd_pkg::LEN_FORMAT;
						r2 = udsd_pkg::BLOCK_LEN;
					end
				end
				udsd_pkg::SID_TRANSFER: begin
					if (len_w < SW'(3)) r2 = udsd_pkg::NRC_LENGTH;
					else if (!act_q) r2 = udsd_pkg::NRC_COND;
					else if (!rr_q) r2 = udsd_pkg::NRC_GENERAL;
					else if (sec_d != exp_q) r2 = udsd_pkg::NRC_SEQUENCE;
					else if (sum_w > SW'(il_q)) r2 = udsd_pkg::NRC_RANGE;
					else begin
						br_d    = sum_w[LW-1:0];
						phase_d = udsd_pkg::PH_PROGRESS;
						exp_d   = exp_q + 8'd1;
						n_d = 2'd2;
						r0  = svc_d + udsd_pkg::POS_OFFSET;
						r1  = sec_d;
					end
				end
				udsd_pkg::SID_EXIT: begin
					if (!act_q || br_q != il_q || !rr_q) r2 = udsd_pkg::NRC_COND;
					else begin
						phase_d = udsd_pkg::PH_COMPLETE;
						act_d   = 1'b0;
						n_d = 2'd1;
						r0  = svc_d + udsd_pkg::POS_OFFSET;
					end
				end
				default: r2 = udsd_pkg::NRC_NOT_SUPP;
			endcase
		end

		// flags reflect the new state for a message word, the held state otherwise
		resp.valid    = end_of_message;
		resp.count    = n_d;
		resp.b0       = r0;
		resp.b1       = r1;
		resp.b2       = r2;
		resp.active   = accept ? act_d : act_q;
		resp.complete = accept ? (phase_d == udsd_pkg::PH_COMPLETE)
		                       : (phase_q == udsd_pkg::PH_COMPLETE);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			br_q    <= '0;
			il_q    <= '0;
			svc_q   <= 8'h00;
			sec_q   <= 8'h00;
			fmt_q   <= 8'h00;
			exp_q   <= 8'd1;
			prog_q  <= 1'b0;
			act_q   <= 1'b0;
			rr_q    <= 1'b0;
			phase_q <= udsd_pkg::PH_IDLE;
		end else if (accept) begin
			pos_q   <= pos_d;
			br_q    <= br_d;
			il_q    <= il_d;
			svc_q   <= svc_d;
			sec_q   <= sec_d;
			fmt_q   <= fmt_d;
			exp_q   <= exp_d;
			prog_q  <= prog_d;
			act_q   <= act_d;
			rr_q    <= rr_d;
			phase_q <= phase_d;
		end
	end

	// size accumulator, cleared by the first byte of each message
	always_ff @(posedge clk) begin
		if (accept) size_q <= size_d;
	end

endmodule
